// ===== sv/its_pkg.sv =====
// shared types, constants and tag lookup for the inline tag stream splitter
// no dependencies; imported by the matcher, the emitter, the top level and the bench
package its_pkg;

    localparam int unsigned OPEN_LEN  = 7;
    localparam int unsigned CLOSE_LEN = 8;
    localparam int unsigned IDX_W     = 3;

    localparam logic [7:0] CHAR_LT = 8'h3C;

    // kind of request on the input side
    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // one unit of output work: a run of held tag bytes plus an optional tail
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] prefix_len;
        logic             reas;
        logic             has_tail;
        logic             tail_done;
        logic [7:0]       tail_byte;
    } job_t;

    // byte idx of the tag that ends the current mode's match
    function automatic logic [7:0] tag_byte(input logic reas, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (reas)
        begin
            case (idx)
                3'd0:    b = 8'h3C; // <
                3'd1:    b = 8'h2F; // /
                3'd2:    b = 8'h74; // t
                3'd3:    b = 8'h68; // h
                3'd4:    b = 8'h69; // i
                3'd5:    b = 8'h6E; // n
                3'd6:    b = 8'h6B; // k
                default: b = 8'h3E; // >
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    b = 8'h3C;
                3'd1:    b = 8'h74;
                3'd2:    b = 8'h68;
                3'd3:    b = 8'h69;
                3'd4:    b = 8'h6E;
                3'd5:    b = 8'h6B;
                3'd6:    b = 8'h3E;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

// ===== sv/its_matcher.sv =====
// tag matcher: mode and partial-match state, turns each request into an output job
// depends on its_pkg
module its_matcher
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          opcode,
    input  logic [7:0]    byte_value,
    output its_pkg::job_t job
);
    import its_pkg::*;

    logic             in_reasoning_reg, in_reasoning_next;
    logic [IDX_W-1:0] matched_reg, matched_next;
    logic             finished_reg, finished_next;

    logic             hit;
    logic             at_end;
    logic [IDX_W-1:0] matched_inc;

    assign matched_inc = matched_reg + 1'b1;
    // the open tag has no eighth byte
    assign hit = (in_reasoning_reg || (matched_reg != IDX_W'(OPEN_LEN))) &&
                 (tag_byte(in_reasoning_reg, matched_reg) == byte_value);
    assign at_end = in_reasoning_reg ? (matched_reg == IDX_W'(CLOSE_LEN - 1))
                                     : (matched_reg == IDX_W'(OPEN_LEN - 1));

    always_comb
    begin
        in_reasoning_next = in_reasoning_reg;
        matched_next      = matched_reg;
        finished_next     = finished_reg;
        job.valid         = 1'b0;
        job.prefix_len    = matched_reg;
        job.reas          = in_reasoning_reg;
        job.has_tail      = 1'b0;
        job.tail_done     = 1'b0;
        job.tail_byte     = byte_value;
        if (accept)
        begin
            if (opcode == OP_FINISH)
            begin
                if (!finished_reg)
                begin
                    finished_next = 1'b1;
                    matched_next  = '0;
                    job.valid     = 1'b1;
                    job.has_tail  = 1'b1;
                    job.tail_done = 1'b1;
                end
            end
            else if (hit)
            begin
                if (at_end)
                begin
                    in_reasoning_next = !in_reasoning_reg;
                    matched_next      = '0;
                end
                else
                begin
                    matched_next = matched_inc;
                end
            end
            else if (byte_value == CHAR_LT)
            begin
                // a stray '<' starts a fresh match after releasing the old prefix
                matched_next = IDX_W'(1);
                job.valid    = (matched_reg != '0);
            end
            else
            begin
                matched_next = '0;
                job.valid    = 1'b1;
                job.has_tail = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reasoning_reg <= 1'b0;
            matched_reg      <= '0;
            finished_reg     <= 1'b0;
        end
        else
        begin
            in_reasoning_reg <= in_reasoning_next;
            matched_reg      <= matched_next;
            finished_reg     <= finished_next;
        end
    end

endmodule

// ===== sv/its_emitter.sv =====
// output side: skid slot plus active job register, serializes held bytes and tail
// depends on its_pkg
module its_emitter
(
    input  logic          clk,
    input  logic          rst_n,
    input  its_pkg::job_t job,
    output logic          in_ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);
    import its_pkg::*;

    job_t             main_reg, main_next;
    job_t             skid_reg, skid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic in_prefix;
    logic piece_last;
    logic main_free;
    logic xfer;

    assign in_prefix = idx_reg < main_reg.prefix_len;
    assign piece_last = in_prefix ? ((idx_reg == main_reg.prefix_len - 1'b1) &&
                                     !main_reg.has_tail)
                                  : 1'b1;

    always_comb
    begin
        if (in_prefix)
        begin
            m_tdata    = tag_byte(main_reg.reas, idx_reg);
            m_tuser[0] = main_reg.reas;
            m_tuser[1] = 1'b0;
        end
        else
        begin
            m_tdata    = main_reg.tail_done ? 8'h00 : main_reg.tail_byte;
            m_tuser[0] = main_reg.tail_done ? 1'b0 : main_reg.reas;
            m_tuser[1] = main_reg.tail_done;
        end
    end

    assign m_tvalid  = main_reg.valid;
    assign m_tlast   = piece_last;
    assign in_ready  = !skid_reg.valid;
    assign xfer      = main_reg.valid && m_tready;
    assign main_free = !main_reg.valid || (xfer && piece_last);

    always_comb
    begin
        main_next = main_reg;
        skid_next = skid_reg;
        idx_next  = idx_reg;
        if (xfer && !piece_last)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (main_free)
        begin
            idx_next = '0;
            if (skid_reg.valid)
            begin
                main_next       = skid_reg;
                skid_next.valid = 1'b0;
            end
            else
            begin
                main_next = job;
            end
        end
        else if (job.valid)
        begin
            skid_next = job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_reg <= '0;
            skid_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            main_reg <= main_next;
            skid_reg <= skid_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

// ===== sv/inline_tag_stream_splitter.sv =====
// a result appears on the master side in the cycle after its request is accepted
//   when the output side is idle
// the input takes one request per cycle while the skid slot is empty; a request releasing
//   n held tag bytes and a tail is sent as n+1 output bytes; the one-entry skid slot takes
//   the next request, then the input stalls until the run drains
// requests that complete or extend a tag give no result
// reset: rst_n asynchronous active low, clears mode, match length, finish flag and output side
module inline_tag_stream_splitter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic       s_tuser,   // [0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] is_reasoning, [1] is_done
    output logic       m_tlast
);
    import its_pkg::*;

    job_t job;
    logic accept;

    assign accept = s_tvalid && s_tready;

    its_matcher u_matcher
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (s_tuser),
        .byte_value (s_tdata),
        .job        (job)
    );

    its_emitter u_emitter
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sv/its_checker.sv =====
// port-level checks for the inline tag stream splitter, attached by bind
// no package dependency
module its_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // done marker ends its request and carries nothing
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == 8'h00) && !m_tuser[0])
        else $error("malformed done marker");

    // input only backs up when a result is waiting
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with idle output");

    // a backed-up input frees once the waiting result goes out
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("input stayed stalled after drain");

endmodule

bind inline_tag_stream_splitter its_checker u_its_checker (.*);

// ===== bench/inline_tag_stream_splitter_tb.sv =====
// self-checking bench for inline_tag_stream_splitter: directed rows, then random tag-heavy text
// depends on its_pkg and splitter rtl; compares every result to an in-bench model or its typed row
`timescale 1ns / 1ps

module inline_tag_stream_splitter_tb;

    import its_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 75;
    localparam int SETTLE      = 12;
    localparam int NUM_DIRECTED = 22;

    typedef struct {
        logic [7:0] out_byte;
        logic       reas;
        logic       done;
        logic       last;
    } split_out_t;

    // typed rows carry their own expectation: zero or one result
    typedef struct {
        logic       op;
        logic [7:0] data;
        bit         typed;
        int         n_typed;
        logic [7:0] t_byte;
        logic       t_reas;
        logic       t_done;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    logic [7:0] open_chars  [8] = '{8'h3C, 8'h74, 8'h68, 8'h69, 8'h6E, 8'h6B, 8'h3E, 8'h00};
    logic [7:0] close_chars [8] = '{8'h3C, 8'h2F, 8'h74, 8'h68, 8'h69, 8'h6E, 8'h6B, 8'h3E};

    stim_row_t dir_rows [NUM_DIRECTED] = '{
        '{OP_BYTE,   8'h41, 1'b1, 1, 8'h41, 1'b0, 1'b0},  // plain 'A' right after reset
        '{OP_BYTE,   8'h00, 1'b1, 1, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'hFF, 1'b1, 1, 8'hFF, 1'b0, 1'b0},
        '{OP_BYTE,   8'h3C, 1'b1, 0, 8'h00, 1'b0, 1'b0},  // '<' is held
        '{OP_BYTE,   8'h2F, 1'b0, 0, 8'h00, 1'b0, 1'b0},  // closing tag is content in normal mode
        '{OP_BYTE,   8'h3C, 1'b0, 0, 8'h00, 1'b0, 1'b0},  // opening tag
        '{OP_BYTE,   8'h74, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'h68, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'h69, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'h6E, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'h6B, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'h3E, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'h78, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'h3C, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'h3C, 1'b0, 0, 8'h00, 1'b0, 1'b0},  // '<' breaks the match and restarts it
        '{OP_BYTE,   8'h74, 1'b0, 0, 8'h00, 1'b0, 1'b0},  // opening tag is content here
        '{OP_BYTE,   8'h3C, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'h2F, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_BYTE,   8'h74, 1'b0, 0, 8'h00, 1'b0, 1'b0},
        '{OP_FINISH, 8'h00, 1'b0, 0, 8'h00, 1'b0, 1'b0},  // flush held prefix as reasoning
        '{OP_FINISH, 8'hA5, 1'b1, 0, 8'h00, 1'b0, 1'b0},  // second finish gives nothing
        '{OP_BYTE,   8'h71, 1'b0, 0, 8'h00, 1'b0, 1'b0}
    };

    // model state
    logic       model_reas;
    int         held_len;
    logic       finish_seen;
    split_out_t released_now [$];

    split_out_t pending_results [$];
    stim_row_t  row_notes [$];

    int   err_cnt;
    int   sent;
    int   idle_pct;
    int   stall_pct;
    bit   hold_req;

    inline_tag_stream_splitter dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [7:0] tag_char(input logic closing, input int idx);
        return closing ? close_chars[idx] : open_chars[idx];
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic emit(input logic [7:0] b, input logic reas, input logic done);
        split_out_t r;
        r.out_byte = b;
        r.reas     = reas;
        r.done     = done;
        r.last     = 1'b0;
        released_now.insert(released_now.size(), r);
    endtask

    task automatic flush_prefix();
        for (int k = 0; k < held_len; k++)
            emit(tag_char(model_reas, k), model_reas, 1'b0);
        held_len = 0;
    endtask

    // works out the results of one accepted request and updates the model state
    task automatic split_request(input logic op, input logic [7:0] b);
        int tlen;
        released_now.delete();
        if (op == OP_FINISH)
        begin
            if (!finish_seen)
            begin
                finish_seen = 1'b1;
                flush_prefix();
                emit(8'h00, 1'b0, 1'b1);
            end
        end
        else
        begin
            tlen = model_reas ? CLOSE_LEN : OPEN_LEN;
            if (held_len < tlen && tag_char(model_reas, held_len) == b)
            begin
                held_len++;
                if (held_len >= tlen)
                begin
                    model_reas = ~model_reas;
                    held_len = 0;
                end
            end
            else
            begin
                flush_prefix();
                if (b == CHAR_LT)
                    held_len = 1;
                else
                    emit(b, model_reas, 1'b0);
            end
        end
        if (released_now.size() > 0)
            released_now[$].last = 1'b1;
    endtask

    always @(posedge clk)
    begin : accept_mon
        stim_row_t  note;
        split_out_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            note = row_notes.pop_front();
            split_request(s_tuser, s_tdata);
            if (note.typed)
            begin
                released_now.delete();
                if (note.n_typed == 1)
                begin
                    r.out_byte = note.t_byte;
                    r.reas     = note.t_reas;
                    r.done     = note.t_done;
                    r.last     = 1'b1;
                    released_now.insert(released_now.size(), r);
                end
            end
            foreach (released_now[i])
                pending_results.insert(pending_results.size(), released_now[i]);
        end
    end

    always @(posedge clk)
    begin : result_mon
        split_out_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", m_tdata, 8'h00);
            else
            begin
                e = pending_results.pop_front();
                if (m_tdata !== e.out_byte)
                    report_mismatch("out_byte", m_tdata, e.out_byte);
                if (m_tuser[0] !== e.reas)
                    report_mismatch("is_reasoning", {7'b0, m_tuser[0]}, {7'b0, e.reas});
                if (m_tuser[1] !== e.done)
                    report_mismatch("is_done", {7'b0, m_tuser[1]}, {7'b0, e.done});
                if (m_tlast !== e.last)
                    report_mismatch("last", {7'b0, m_tlast}, {7'b0, e.last});
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on demand
    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(input stim_row_t r);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.data;
        s_tuser  <= r.op;
        row_notes.insert(row_notes.size(), r);
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    task automatic send_plain(input logic op, input logic [7:0] b);
        stim_row_t r;
        r = '{op, b, 1'b0, 0, 8'h00, 1'b0, 1'b0};
        send_request(r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // mostly whole or broken tags with random text between them
    task automatic send_fragment();
        int         kind;
        int         n;
        int         cut;
        logic       closing;
        logic [7:0] brk;
        kind    = $urandom_range(99);
        closing = 1'($urandom_range(1));
        n       = closing ? CLOSE_LEN : OPEN_LEN;
        if (kind < 35)
        begin
            for (int k = 0; k < n; k++)
                send_plain(OP_BYTE, tag_char(closing, k));
        end
        else if (kind < 55)
        begin
            cut = $urandom_range(n - 1, 1);
            for (int k = 0; k < cut; k++)
                send_plain(OP_BYTE, tag_char(closing, k));
            case ($urandom_range(2))
                0:       brk = CHAR_LT;
                1:       brk = 8'($urandom_range(255));
                default: brk = tag_char(~closing, cut);
            endcase
            send_plain(OP_BYTE, brk);
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(4, 1))
                send_plain(OP_BYTE, 8'($urandom_range(255)));
        end
        else if (kind < 95)
        begin
            repeat ($urandom_range(6, 1))
                send_plain(OP_BYTE, tag_char(1'($urandom_range(1)), $urandom_range(7)));
        end
        else
            send_plain(OP_FINISH, 8'($urandom_range(255)));
    endtask

    initial
    begin
        int idle_set  [4];
        int stall_set [4];
        int start;
        bit hold_done;
        idle_set    = '{0, 60, 0, 38};
        stall_set   = '{0, 0, 60, 38};
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = OP_BYTE;
        rst_n       = 1'b0;
        model_reas  = 1'b0;
        held_len    = 0;
        finish_seen = 1'b0;
        err_cnt     = 0;
        sent        = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i]);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            start     = sent;
            while (sent - start < PHASE_ITEMS)
            begin
                // receiver holds off while requests keep coming
                if (!hold_done && sent - start >= 10)
                begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                send_fragment();
            end
            wait_drained();
        end

        repeat (SETTLE) @(posedge clk);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== inline_tag_stream_splitter.f =====
sv/its_pkg.sv
sv/its_matcher.sv
sv/its_emitter.sv
sv/inline_tag_stream_splitter.sv
sv/its_checker.sv
bench/inline_tag_stream_splitter_tb.sv
